// File: design/heat_stencil_step_macros.svh
// Assertion macros shared by the heat stencil step modules.
// Depends on nothing; included by the modules that carry checks.
`ifndef HEAT_STENCIL_STEP_MACROS_SVH
`define HEAT_STENCIL_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HSS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hss_pkg.sv
// Package for the heat stencil step: sizes, register indexes, configuration
// record and the command set between controller and datapath. No dependencies.
package hss_pkg;

    localparam int SEGMENT_POINTS = 1024;
    localparam int IDX_W          = $clog2(SEGMENT_POINTS + 5);
    localparam int CFG_IDX_W      = 3;
    localparam int DIV_STEPS      = 14;     // 56-bit dividend, four bits a cycle
    localparam int HORNER_TERMS   = 10;
    localparam int SQUARINGS      = 4;
    localparam logic [3:0] DIFF_DIVISOR = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFFUSION_GAIN = 3'd0,
        CFG_SOURCE_GAIN    = 3'd1,
        CFG_TIME_STEP      = 3'd2,
        CFG_GRID_SPACING   = 3'd3,
        CFG_SEGMENT_START  = 3'd4,
        CFG_LEFT_BOUNDARY  = 3'd5,
        CFG_RIGHT_BOUNDARY = 3'd6,
        CFG_SEGMENT_ENDS   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [30:0]        diffusion_gain;
        logic [30:0]        source_gain;
        logic [30:0]        time_step;
        logic [30:0]        grid_spacing;
        logic signed [31:0] segment_start;
        logic signed [31:0] left_boundary;
        logic signed [31:0] right_boundary;
        logic [1:0]         segment_ends;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_MUL_GLO,
        OP_MUL_GHI,
        OP_DIV_DIFF,
        OP_TAKE_DIFF,
        OP_MUL_AD,
        OP_TAKE_X,
        OP_MUL_YR,
        OP_DIV_HORNER,
        OP_TAKE_R,
        OP_MUL_RR,
        OP_TAKE_SQ,
        OP_TAKE_EX,
        OP_MUL_SRC,
        OP_TAKE_SRC,
        OP_TAKE_RHS,
        OP_MUL_DT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       first_sample;
        logic       sub_left;
        logic       sub_right;
        logic       force_left;
        logic       force_right;
        logic [3:0] divisor;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

// File: design/hss_datapath.sv
// Datapath of the heat stencil step: sample window, shared multiplier,
// small-constant divider and the result registers. Uses hss_pkg and the macros.
`include "heat_stencil_step_macros.svh"

module hss_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hss_pkg::cfg_t       cfg,
    input  logic signed [31:0]  s_temperature,
    input  hss_pkg::dp_cmd_t    cmd,
    output hss_pkg::dp_status_t status,
    output logic signed [31:0]  out_new_temperature,
    output logic signed [31:0]  out_source_value
);
    import hss_pkg::*;

    localparam logic signed [55:0] MAX_W = 56'sh0000007FFFFFFF;
    localparam logic signed [55:0] MIN_W = 56'shFFFFFF80000000;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > MAX_W) begin
            r = 32'sh7FFFFFFF;
        end else if (v < MIN_W) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [31:0] win_reg [4];
    logic signed [31:0] sim_time_reg, pos_reg;
    logic signed [31:0] center_reg;
    logic               lap_neg_reg;
    logic [37:0]        al_reg;
    logic [17:0]        ad_reg;
    logic               far_reg;
    logic [63:0]        prod_reg;
    logic [53:0]        m_reg;
    logic signed [54:0] diff_reg;
    logic [29:0]        y_reg;
    logic [30:0]        r_reg;
    logic [16:0]        ex_reg;
    logic signed [31:0] src_reg;
    logic               rhs_neg_reg;
    logic [31:0]        ar_reg;
    logic signed [31:0] out_nt_reg, out_src_reg;
    logic [55:0]        div_q_reg;
    logic [3:0]         div_rem_reg, div_d_reg;
    logic [3:0]         div_cnt_reg;

    // Sample after boundary substitution and the five-point Laplacian.
    logic signed [31:0] t_eff;
    logic signed [38:0] lap;
    assign t_eff = cmd.sub_right ? cfg.right_boundary :
                   cmd.sub_left  ? cfg.left_boundary  : s_temperature;
    assign lap = (39'(win_reg[1]) <<< 4) + (39'(win_reg[3]) <<< 4)
               - 39'(win_reg[0]) - 39'(t_eff)
               - (39'(win_reg[2]) <<< 5) + (39'(win_reg[2]) <<< 1);

    logic signed [32:0] pos_diff;
    logic [32:0]        adist;
    assign pos_diff = 33'(pos_reg) - 33'(sim_time_reg);
    assign adist    = pos_diff[32] ? 33'(-pos_diff) : 33'(pos_diff);

    // Shared multiplier operand selection.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_GLO: begin
                mul_a = {1'b0, cfg.diffusion_gain};
                mul_b = al_reg[31:0];
            end
            OP_MUL_GHI: begin
                mul_a = {1'b0, cfg.diffusion_gain};
                mul_b = {26'd0, al_reg[37:32]};
            end
            OP_MUL_AD: begin
                mul_a = {14'd0, ad_reg};
                mul_b = {14'd0, ad_reg};
            end
            OP_MUL_YR: begin
                mul_a = {2'd0, y_reg};
                mul_b = {1'b0, r_reg};
            end
            OP_MUL_RR: begin
                mul_a = {1'b0, r_reg};
                mul_b = {1'b0, r_reg};
            end
            OP_MUL_SRC: begin
                mul_a = {1'b0, cfg.source_gain};
                mul_b = {15'd0, ex_reg};
            end
            OP_MUL_DT: begin
                mul_a = {1'b0, cfg.time_step};
                mul_b = ar_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Divider by a small constant, four restoring steps a cycle.
    logic [55:0] div_q_step;
    logic [3:0]  div_rem_step;
    always_comb begin
        logic [4:0] t;
        div_q_step   = div_q_reg;
        div_rem_step = div_rem_reg;
        for (int i = 0; i < 4; i++) begin
            t          = {div_rem_step, div_q_step[55]};
            div_q_step = {div_q_step[54:0], 1'b0};
            if (t >= {1'b0, div_d_reg}) begin
                div_rem_step  = 4'(t - {1'b0, div_d_reg});
                div_q_step[0] = 1'b1;
            end else begin
                div_rem_step = t[3:0];
            end
        end
    end

    logic div_start;
    logic [55:0] div_dividend;
    assign div_start = (cmd.op == OP_DIV_DIFF) || (cmd.op == OP_DIV_HORNER);
    assign div_dividend = (cmd.op == OP_DIV_DIFF)
                        ? 56'(m_reg) + (56'(prod_reg[37:0]) << 16) + 56'd6
                        : 56'(prod_reg[60:30]);

    // Intermediate values for the later steps.
    logic [20:0]        x_val;
    logic [31:0]        sq_sum;
    logic [31:0]        ex_sum;
    logic [47:0]        src_sum;
    logic signed [55:0] rhs_sum;
    logic signed [31:0] rhs_val;
    logic [62:0]        dl_sum;
    logic signed [55:0] delta;
    logic signed [31:0] nt_val;
    assign x_val   = 21'((prod_reg[36:0] + 37'd32768) >> 16);
    assign sq_sum  = 32'((prod_reg[61:0] + 62'd536870912) >> 30);
    assign ex_sum  = (32'(r_reg) + 32'd8192) >> 14;
    assign src_sum = prod_reg[47:0] + 48'd32768;
    assign rhs_sum = 56'(diff_reg) + 56'(src_reg);
    assign rhs_val = sat32(rhs_sum);
    assign dl_sum  = (prod_reg[62:0] + 63'd32768) >> 16;
    assign delta   = rhs_neg_reg ? -$signed({8'd0, dl_sum[47:0]})
                                 : $signed({8'd0, dl_sum[47:0]});
    assign nt_val  = sat32(56'(center_reg) + delta);

    // Model state and divider count: cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
            sim_time_reg <= '0;
            pos_reg      <= '0;
            div_cnt_reg  <= '0;
        end else begin
            if (cmd.op == OP_LOAD) begin
                if (cmd.first_sample) begin
                    sim_time_reg <= sat32(56'(sim_time_reg) + 56'(cfg.time_step));
                    pos_reg      <= cfg.segment_start;
                end
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= t_eff;
            end
            if (cmd.op == OP_FINISH) begin
                pos_reg <= sat32(56'(pos_reg) + 56'(cfg.grid_spacing));
            end
            if (div_start) begin
                div_cnt_reg <= 4'(DIV_STEPS);
            end else if (div_cnt_reg != 4'd0) begin
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (div_start) begin
            div_q_reg   <= div_dividend;
            div_rem_reg <= '0;
            div_d_reg   <= cmd.divisor;
        end else if (div_cnt_reg != 4'd0) begin
            div_q_reg   <= div_q_step;
            div_rem_reg <= div_rem_step;
        end
        if (mul_a != 32'd0 || mul_b != 32'd0 || cmd.op == OP_MUL_GLO
                || cmd.op == OP_MUL_GHI || cmd.op == OP_MUL_AD || cmd.op == OP_MUL_YR
                || cmd.op == OP_MUL_RR || cmd.op == OP_MUL_SRC || cmd.op == OP_MUL_DT) begin
            prod_reg <= mul_p;
        end
        case (cmd.op)
            OP_LOAD: begin
                center_reg  <= win_reg[2];
                lap_neg_reg <= lap[38];
                al_reg      <= lap[38] ? 38'(-lap) : 38'(lap);
            end
            OP_PREP: begin
                ad_reg  <= adist[17:0];
                far_reg <= (adist[32:18] != '0);
            end
            OP_MUL_GHI: begin
                m_reg <= {6'd0, prod_reg[63:16]};
            end
            OP_TAKE_DIFF: begin
                diff_reg <= lap_neg_reg ? -$signed({1'b0, div_q_reg[53:0]})
                                        : $signed({1'b0, div_q_reg[53:0]});
            end
            OP_TAKE_X: begin
                y_reg <= {x_val[19:0], 10'd0};
                r_reg <= 31'h40000000;
            end
            OP_TAKE_R: begin
                r_reg <= 31'h40000000 - div_q_reg[30:0];
            end
            OP_TAKE_SQ: begin
                r_reg <= sq_sum[30:0];
            end
            OP_TAKE_EX: begin
                ex_reg <= far_reg ? 17'd0 : ex_sum[16:0];
            end
            OP_TAKE_SRC: begin
                src_reg <= src_sum[47] ? 32'sh7FFFFFFF : $signed(src_sum[47:16]);
            end
            OP_TAKE_RHS: begin
                rhs_neg_reg <= rhs_val[31];
                ar_reg      <= rhs_val[31] ? 32'(-33'(rhs_val)) : 32'(rhs_val);
            end
            OP_FINISH: begin
                out_src_reg <= src_reg;
                if (cmd.force_right) begin
                    out_nt_reg <= cfg.right_boundary;
                end else if (cmd.force_left) begin
                    out_nt_reg <= cfg.left_boundary;
                end else begin
                    out_nt_reg <= nt_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign status.div_busy     = (div_cnt_reg != 4'd0);
    assign out_new_temperature = out_nt_reg;
    assign out_source_value    = out_src_reg;

    `HSS_ASSERT_IMP(a_div_idle_on_start, aclk, aresetn, div_start, div_cnt_reg == 4'd0, "divider restarted while busy")

endmodule

// File: design/hss_controller.sv
// Controller of the heat stencil step: sample counter, step sequencer and
// output handshake. Uses hss_pkg and the assertion macros.
`include "heat_stencil_step_macros.svh"

module hss_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          segment_ends,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output hss_pkg::dp_cmd_t    cmd,
    input  hss_pkg::dp_status_t status
);
    import hss_pkg::*;

    localparam logic [IDX_W-1:0] IDX_FIRST_RES = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_LAST_RES  = IDX_W'(SEGMENT_POINTS + 3);
    localparam logic [IDX_W-1:0] IDX_RIGHT     = IDX_W'(SEGMENT_POINTS + 1);
    localparam logic [IDX_W-1:0] IDX_SAT       = IDX_W'(SEGMENT_POINTS + 4);
    localparam logic [IDX_W-1:0] IDX_LEFT_MAX  = IDX_W'(2);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_MUL_GLO, S_MUL_GHI, S_DIV_DIFF, S_WAIT_DIFF, S_TAKE_DIFF,
        S_MUL_AD, S_TAKE_X, S_MUL_YR, S_DIV_H, S_WAIT_H, S_TAKE_R, S_MUL_RR,
        S_TAKE_SQ, S_TAKE_EX, S_MUL_SRC, S_TAKE_SRC, S_TAKE_RHS, S_MUL_DT, S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       hn_reg, hn_next;
    logic [1:0]       sq_reg, sq_next;
    logic             fl_reg, fl_next, fr_reg, fr_next, last_reg, last_next;
    logic             out_valid_reg, out_valid_next, out_last_reg, out_last_next;

    logic accept, do_res;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign do_res   = (idx_reg >= IDX_FIRST_RES) && (idx_reg <= IDX_LAST_RES);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hn_next        = hn_reg;
        sq_next        = sq_reg;
        fl_next        = fl_reg;
        fr_next        = fr_reg;
        last_next      = last_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        cmd              = '0;
        cmd.op           = OP_NONE;
        cmd.first_sample = (idx_reg == '0);
        cmd.sub_left     = segment_ends[0] && (idx_reg <= IDX_LEFT_MAX);
        cmd.sub_right    = segment_ends[1] && (idx_reg >= IDX_RIGHT);
        cmd.force_left   = fl_reg;
        cmd.force_right  = fr_reg;
        cmd.divisor      = (state_reg == S_DIV_DIFF) ? DIFF_DIVISOR : hn_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.op    = OP_LOAD;
                    fl_next   = segment_ends[0] && (idx_reg == IDX_FIRST_RES);
                    fr_next   = segment_ends[1] && (idx_reg == IDX_LAST_RES);
                    last_next = s_tlast || (idx_reg == IDX_LAST_RES);
                    if (s_tlast) begin
                        idx_next = '0;
                    end else if (idx_reg < IDX_SAT) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                    if (do_res) begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP: begin
                cmd.op     = OP_PREP;
                state_next = S_MUL_GLO;
            end
            S_MUL_GLO: begin
                cmd.op     = OP_MUL_GLO;
                state_next = S_MUL_GHI;
            end
            S_MUL_GHI: begin
                cmd.op     = OP_MUL_GHI;
                state_next = S_DIV_DIFF;
            end
            S_DIV_DIFF: begin
                cmd.op     = OP_DIV_DIFF;
                state_next = S_WAIT_DIFF;
            end
            S_WAIT_DIFF: begin
                if (!status.div_busy) begin
                    state_next = S_TAKE_DIFF;
                end
            end
            S_TAKE_DIFF: begin
                cmd.op     = OP_TAKE_DIFF;
                state_next = S_MUL_AD;
            end
            S_MUL_AD: begin
                cmd.op     = OP_MUL_AD;
                state_next = S_TAKE_X;
            end
            S_TAKE_X: begin
                cmd.op     = OP_TAKE_X;
                hn_next    = 4'(HORNER_TERMS);
                state_next = S_MUL_YR;
            end
            S_MUL_YR: begin
                cmd.op     = OP_MUL_YR;
                state_next = S_DIV_H;
            end
            S_DIV_H: begin
                cmd.op     = OP_DIV_HORNER;
                state_next = S_WAIT_H;
            end
            S_WAIT_H: begin
                if (!status.div_busy) begin
                    state_next = S_TAKE_R;
                end
            end
            S_TAKE_R: begin
                cmd.op  = OP_TAKE_R;
                hn_next = hn_reg - 4'd1;
                if (hn_reg == 4'd1) begin
                    sq_next    = '0;
                    state_next = S_MUL_RR;
                end else begin
                    state_next = S_MUL_YR;
                end
            end
            S_MUL_RR: begin
                cmd.op     = OP_MUL_RR;
                state_next = S_TAKE_SQ;
            end
            S_TAKE_SQ: begin
                cmd.op  = OP_TAKE_SQ;
                sq_next = sq_reg + 2'd1;
                if (sq_reg == 2'(SQUARINGS - 1)) begin
                    state_next = S_TAKE_EX;
                end else begin
                    state_next = S_MUL_RR;
                end
            end
            S_TAKE_EX: begin
                cmd.op     = OP_TAKE_EX;
                state_next = S_MUL_SRC;
            end
            S_MUL_SRC: begin
                cmd.op     = OP_MUL_SRC;
                state_next = S_TAKE_SRC;
            end
            S_TAKE_SRC: begin
                cmd.op     = OP_TAKE_SRC;
                state_next = S_TAKE_RHS;
            end
            S_TAKE_RHS: begin
                cmd.op     = OP_TAKE_RHS;
                state_next = S_MUL_DT;
            end
            S_MUL_DT: begin
                cmd.op     = OP_MUL_DT;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            hn_reg        <= '0;
            sq_reg        <= '0;
            fl_reg        <= 1'b0;
            fr_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hn_reg        <= hn_next;
            sq_reg        <= sq_next;
            fl_reg        <= fl_next;
            fr_reg        <= fr_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    `HSS_ASSERT_IMP(a_finish_has_room, aclk, aresetn, cmd.op == OP_FINISH, !out_valid_reg || m_tready, "result overwrote a pending transfer")
    `HSS_ASSERT_IMP(a_index_saturates, aclk, aresetn, 1'b1, idx_reg <= IDX_SAT, "sample counter beyond saturation")
    `HSS_ASSERT_NEXT(a_no_result_idle, aclk, aresetn, accept && !do_res, state_reg == S_IDLE && !$rose(m_tvalid), "sample without result started work")

endmodule

// File: design/heat_stencil_step.sv
// Top level of the heat stencil step: configuration registers and the
// controller and datapath instances. Uses hss_pkg, hss_controller, hss_datapath.

// One transfer on the input stream is one grid sample of a pass, halo cells
// included; s_tlast ends the pass. Samples that update no interior cell are
// taken while the sequencer stays idle. A sample that yields a result
// occupies the sequencer from its transfer until the input is ready again:
// the Taylor series for the Gaussian source runs ten rounds through one
// shared 32 by 32 bit multiplier and a divider that retires four quotient
// bits a cycle, and the diffusion term needs one more division by twelve.
// Input is accepted only while the sequencer is idle, but a finished result
// waits in the output register, so the next sample is taken while the
// previous result is still offered. Configuration is written through the
// plain write port and should only change while no pass is in progress.
module heat_stencil_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                 cfg_wdata,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] temperature
    input  logic                        s_tlast,   // last_sample
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // [31:0] new_temperature, [63:32] source_value
    output logic                        m_tlast    // last_of_pass
);
    import hss_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic signed [31:0] new_temperature, source_value;

    // Register file; the values after reset give a working default segment.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.diffusion_gain <= 31'd6553600;
            cfg_reg.source_gain    <= 31'd65536;
            cfg_reg.time_step      <= 31'd229;
            cfg_reg.grid_spacing   <= 31'd6554;
            cfg_reg.segment_start  <= '0;
            cfg_reg.left_boundary  <= '0;
            cfg_reg.right_boundary <= '0;
            cfg_reg.segment_ends   <= 2'b11;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_DIFFUSION_GAIN: cfg_reg.diffusion_gain <= cfg_wdata[30:0];
                CFG_SOURCE_GAIN:    cfg_reg.source_gain    <= cfg_wdata[30:0];
                CFG_TIME_STEP:      cfg_reg.time_step      <= cfg_wdata[30:0];
                CFG_GRID_SPACING:   cfg_reg.grid_spacing   <= cfg_wdata[30:0];
                CFG_SEGMENT_START:  cfg_reg.segment_start  <= $signed(cfg_wdata);
                CFG_LEFT_BOUNDARY:  cfg_reg.left_boundary  <= $signed(cfg_wdata);
                CFG_RIGHT_BOUNDARY: cfg_reg.right_boundary <= $signed(cfg_wdata);
                CFG_SEGMENT_ENDS:   cfg_reg.segment_ends   <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // The controller sequences one result through the datapath, one operation
    // a cycle except while waiting on the divider or the output, and owns the handshake on both streams.
    hss_controller u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .segment_ends (cfg_reg.segment_ends),
        .s_tvalid     (s_tvalid),
        .s_tlast      (s_tlast),
        .s_tready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

    // The datapath holds the sample window, the simulated time and the source
    // position, and the output data register.
    hss_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .s_temperature       ($signed(s_tdata)),
        .cmd                 (cmd),
        .status              (status),
        .out_new_temperature (new_temperature),
        .out_source_value    (source_value)
    );

    assign m_tdata = {source_value, new_temperature};

endmodule

// File: tb/sv/heat_stencil_checker.sv
// Checker for the heat stencil step: watches the configuration port and both
// streams, predicts every result and compares it. Uses hss_pkg.
module heat_stencil_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import hss_pkg::*;

    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint LAST_CELL = SEGMENT_POINTS + 3;

    typedef struct {
        logic [31:0] new_temp;
        logic [31:0] source;
        logic        last;
    } cell_update_t;

    cell_update_t updates_due[$];

    // Shadow registers and stencil state.
    logic [30:0] diff_gain, src_gain, dt, spacing;
    longint      seg_start, left_temp, right_temp;
    logic [1:0]  ends;
    longint      window[4];
    longint      cell_idx;
    longint      sim_t, src_pos;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Gaussian exp(-d^2) in Q16.16: Horner series on d^2/16, squared four times.
    function automatic longint gaussian(longint d);
        longint unsigned ad, x, y, r;
        ad = (d < 0) ? -d : d;
        if (ad >= (64'd4 << 16)) return 0;
        x = (ad * ad + 64'd32768) >> 16;
        y = x << 10;
        if (y >= Q30) return 0;
        r = Q30;
        for (int n = 10; n >= 1; n--) r = Q30 - ((y * r) >> 30) / n;
        for (int k = 0; k < 4; k++) r = (r * r + (64'd1 << 29)) >> 30;
        return longint'((r + 64'd8192) >> 14);
    endfunction

    // Advances the stencil by one sample and queues the update it yields.
    function automatic void take_sample(logic [31:0] data, logic last);
        longint t, lap, diff, ex, src, rhs, delta, nt;
        longint unsigned al, m, ar;
        cell_update_t u;
        t = longint'($signed(data));
        if (cell_idx == 0) begin
            sim_t = sat32(sim_t + longint'(dt));
            src_pos = seg_start;
        end
        if (ends[0] && cell_idx <= 2) t = left_temp;
        if (ends[1] && cell_idx >= SEGMENT_POINTS + 1) t = right_temp;
        if (cell_idx >= 4 && cell_idx <= LAST_CELL) begin
            lap = -window[0] + 16 * window[1] - 30 * window[2] + 16 * window[3] - t;
            al = (lap < 0) ? -lap : lap;
            m = longint'(diff_gain >> 16) * al + ((longint'(diff_gain[15:0]) * al) >> 16);
            diff = longint'((m + 64'd6) / 64'd12);
            if (lap < 0) diff = -diff;
            ex = gaussian(src_pos - sim_t);
            src = sat32(longint'((longint'(src_gain) * ex + 64'd32768) >> 16));
            rhs = sat32(diff + src);
            ar = (rhs < 0) ? -rhs : rhs;
            delta = longint'((longint'(dt) * ar + 64'd32768) >> 16);
            if (rhs < 0) delta = -delta;
            nt = sat32(window[2] + delta);
            if (ends[0] && cell_idx == 4) nt = left_temp;
            if (ends[1] && cell_idx == LAST_CELL) nt = right_temp;
            u.new_temp = nt[31:0];
            u.source = src[31:0];
            u.last = last || (cell_idx == LAST_CELL);
            updates_due.push_back(u);
            src_pos = sat32(src_pos + longint'(spacing));
        end
        window[0] = window[1];
        window[1] = window[2];
        window[2] = window[3];
        window[3] = t;
        if (last) cell_idx = 0;
        else if (cell_idx < SEGMENT_POINTS + 4) cell_idx++;
    endfunction

    always @(posedge aclk) begin
        cell_update_t u;
        if (!aresetn) begin
            diff_gain = 31'd6553600;
            src_gain = 31'd65536;
            dt = 31'd229;
            spacing = 31'd6554;
            seg_start = 0;
            left_temp = 0;
            right_temp = 0;
            ends = 2'b11;
            window = '{0, 0, 0, 0};
            cell_idx = 0;
            sim_t = 0;
            src_pos = 0;
            updates_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_DIFFUSION_GAIN: diff_gain = cfg_wdata[30:0];
                    CFG_SOURCE_GAIN:    src_gain = cfg_wdata[30:0];
                    CFG_TIME_STEP:      dt = cfg_wdata[30:0];
                    CFG_GRID_SPACING:   spacing = cfg_wdata[30:0];
                    CFG_SEGMENT_START:  seg_start = longint'($signed(cfg_wdata));
                    CFG_LEFT_BOUNDARY:  left_temp = longint'($signed(cfg_wdata));
                    CFG_RIGHT_BOUNDARY: right_temp = longint'($signed(cfg_wdata));
                    CFG_SEGMENT_ENDS:   ends = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            // A result never leaves in the cycle its sample arrives, so the
            // output side is handled first.
            if (m_tvalid && m_tready) begin
                if (updates_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result: temp %h source %h last %b",
                                 m_tdata[31:0], m_tdata[63:32], m_tlast);
                end else begin
                    u = updates_due.pop_front();
                    if (m_tdata[31:0] !== u.new_temp || m_tdata[63:32] !== u.source
                        || m_tlast !== u.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected temp %h source %h last %b, got %h %h %b",
                                     u.new_temp, u.source, u.last,
                                     m_tdata[31:0], m_tdata[63:32], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) take_sample(s_tdata, s_tlast);
        end
        pending = updates_due.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the heat stencil step testbench: clock, reset, stimulus and verdict.
// Depends on hss_pkg, heat_stencil_step and heat_stencil_checker.
module testbench;
    import hss_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] temperature
    logic        s_tlast = 1'b0;   // last_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] new_temperature, [63:32] source_value
    logic        m_tlast;          // last_of_pass
    int          fail_count;
    int          pending;

    // Idle percentages of the sender and the receiver for the current phase.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Running copy of the simulation time, so that segment positions can be
    // placed where the Gaussian source is not negligible.
    longint      sim_guess = 0;
    longint      step_now = 229;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    heat_stencil_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    heat_stencil_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver stalls at random, at the rate the current phase sets.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Safety net: the slowest correct run finishes well inside this time.
    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // All tasks below start and end at a falling edge.
    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TIME_STEP) step_now = longint'(value[30:0]);
    endtask

    // Presents one sample, with random gaps before it, and holds it until the
    // transfer completes. A pass starting advances the time estimate.
    task automatic send_sample(logic [31:0] temp, logic last, bit first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= temp;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (first) sim_guess = clip32(sim_guess + step_now);
    endtask

    // Waits until every expected result has come out, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_temp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 32'($signed($urandom_range(0, 131072000)) - 65536000);
        if (sel < 85) return $urandom;
        case ($urandom_range(2))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return 32'h0;
        endcase
    endfunction

    // Writes every register. Mode 0 puts them at their highest values, mode 1
    // at their lowest, any other mode picks moderate random values with the
    // segment placed near the current source peak.
    task automatic set_config(int mode);
        longint start_pos;
        start_pos = clip32(sim_guess + step_now
                           + longint'($urandom_range(0, 524288)) - 262144);
        if (mode == 0) begin
            write_reg(CFG_DIFFUSION_GAIN, 32'h7FFF_FFFF);
            write_reg(CFG_SOURCE_GAIN, 32'h7FFF_FFFF);
            write_reg(CFG_TIME_STEP, 32'h7FFF_FFFF);
            write_reg(CFG_GRID_SPACING, 32'h7FFF_FFFF);
            write_reg(CFG_SEGMENT_START, 32'h7FFF_FFFF);
            write_reg(CFG_LEFT_BOUNDARY, 32'h7FFF_FFFF);
            write_reg(CFG_RIGHT_BOUNDARY, 32'h7FFF_FFFF);
            write_reg(CFG_SEGMENT_ENDS, 32'd3);
        end else if (mode == 1) begin
            write_reg(CFG_DIFFUSION_GAIN, 32'd0);
            write_reg(CFG_SOURCE_GAIN, 32'd0);
            write_reg(CFG_TIME_STEP, 32'd0);
            write_reg(CFG_GRID_SPACING, 32'd0);
            write_reg(CFG_SEGMENT_START, 32'h8000_0000);
            write_reg(CFG_LEFT_BOUNDARY, 32'h8000_0000);
            write_reg(CFG_RIGHT_BOUNDARY, 32'h8000_0000);
            write_reg(CFG_SEGMENT_ENDS, 32'd0);
        end else begin
            write_reg(CFG_DIFFUSION_GAIN, $urandom_range(0, 20000000));
            write_reg(CFG_SOURCE_GAIN, $urandom_range(0, 1 << 22));
            write_reg(CFG_TIME_STEP, $urandom_range(0, 4000));
            write_reg(CFG_GRID_SPACING, $urandom_range(0, 30000));
            write_reg(CFG_SEGMENT_START, start_pos[31:0]);
            write_reg(CFG_LEFT_BOUNDARY, pick_temp());
            write_reg(CFG_RIGHT_BOUNDARY, pick_temp());
            write_reg(CFG_SEGMENT_ENDS, $urandom_range(0, 3));
        end
    endtask

    // One pass of the given length with random temperatures.
    task automatic run_pass(int len);
        for (int i = 0; i < len; i++)
            send_sample(pick_temp(), i == len - 1, i == 0);
    endtask

    initial begin
        int sent;
        int len;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Reset values, both domain ends active: a short pass
        // ending at the first result, then extreme temperatures.
        run_pass(5);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        // Pass too short to reach any interior cell.
        run_pass(3);
        run_pass(1);
        drain();
        // Highest register values saturate time, position and every sum.
        set_config(0);
        run_pass(6);
        drain();
        set_config(1);
        run_pass(6);
        drain();

        // One full pass with the right domain end, carried a few samples past
        // its end so that the sample counter saturates before the last one.
        set_config(2);
        write_reg(CFG_SEGMENT_ENDS, 32'd2);
        for (int i = 0; i < SEGMENT_POINTS + 8; i++)
            send_sample(pick_temp(), i == SEGMENT_POINTS + 7, i == 0);

        // Random part in four idling phases, with a fresh register setting
        // every few passes once the block has gone quiet.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            sent = 0;
            while (sent < 110) begin
                drain();
                set_config(($urandom_range(9) == 0) ? $urandom_range(1) : 2);
                for (int p = 0; p < 3; p++) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(1, 6)
                                                   : $urandom_range(5, 30);
                    run_pass(len);
                    sent += len;
                end
            end
        end

        drain();
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
